// File: src/wjed_pkg.sv
// Shared constants and types for the weighted Jaccard edge distance block.
`timescale 1ns / 1ps
`default_nettype none

package wjed_pkg;

   localparam int WeightPortBits    = 16;
   localparam int WeightBitsDefault = 16;
   localparam int FieldBits         = 17;
   localparam int FracBits          = 16;
   localparam int SumBits           = 33;
   localparam int MaxEdges          = 65536;
   localparam int Field17Max        = 131071;

   localparam int CountCapInt = (MaxEdges < Field17Max) ? MaxEdges : Field17Max;
   localparam logic [FieldBits-1:0] CountCap = FieldBits'(CountCapInt);
   localparam logic [FieldBits-1:0] OneQ16   = FieldBits'(1 << FracBits);

   // divider: one quotient bit per cycle, 17 bits covers 0 .. 65536
   localparam int DivSteps    = FracBits + 1;
   localparam int DivStepBits = $clog2(DivSteps);

   localparam int QueueDepth  = 4;
   localparam int QptrBits    = $clog2(QueueDepth);
   localparam int QcountBits  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic is_union;
      logic is_shared;
      logic divide;
      logic last;
   } edge_flags_type;

   localparam int EdgeFlagBits = $bits(edge_flags_type);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// File: src/wjed_front.sv
// Front end: takes an edge item, masks and orders the weights, classifies it.
`timescale 1ns / 1ps
`default_nettype none

module wjed_front
   import wjed_pkg::*;
#(
   parameter int WW = WeightBitsDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_in_first,
   input  wire logic                      req_in_second,
   input  wire logic [WeightPortBits-1:0] req_weight_first,
   input  wire logic [WeightPortBits-1:0] req_weight_second,
   input  wire logic                      req_last_edge,
   input  wire logic                      q_full,
   output logic                           q_push,
   output edge_flags_type                 flags,
   output logic [WW-1:0]                  weight_hi,
   output logic [WW-1:0]                  weight_lo
);

   logic           valid_ff;
   edge_flags_type flags_ff;
   edge_flags_type flags_in;
   logic [WW-1:0]  hi_ff;
   logic [WW-1:0]  lo_ff;
   logic [WW-1:0]  w1;
   logic [WW-1:0]  w2;
   logic [WW-1:0]  hi_in;
   logic [WW-1:0]  lo_in;
   logic           take;

   assign w1 = req_weight_first[WW-1:0];
   assign w2 = req_weight_second[WW-1:0];

   always_comb begin
      hi_in              = (w1 > w2) ? w1 : w2;
      lo_in              = (w1 > w2) ? w2 : w1;
      flags_in.is_union  = req_in_first | req_in_second;
      flags_in.is_shared = req_in_first & req_in_second;
      flags_in.divide    = req_in_first & req_in_second & (hi_in != '0);
      flags_in.last      = req_last_edge;
   end

   assign q_push    = valid_ff & ~q_full;
   assign req_stall = valid_ff & q_full;
   assign take      = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         if (take) begin
            valid_ff <= 1'b1;
         end else if (q_push) begin
            valid_ff <= 1'b0;
         end
      end
      if (take) begin
         flags_ff <= flags_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
      end
   end

   assign flags     = flags_ff;
   assign weight_hi = hi_ff;
   assign weight_lo = lo_ff;

endmodule

`default_nettype wire

// File: src/wjed_queue.sv
// Short queue between the front end and the accumulating back end.
`timescale 1ns / 1ps
`default_nettype none

module wjed_queue
   import wjed_pkg::*;
#(
   parameter int DATA_W = EdgeFlagBits + 2 * WeightBitsDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] wdata,
   output logic                   full,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      rdata,
   output logic                   empty
);

   logic [DATA_W-1:0]     entry_ff [QueueDepth];
   logic [QptrBits-1:0]   wr_ptr_ff;
   logic [QptrBits-1:0]   rd_ptr_ff;
   logic [QcountBits-1:0] count_ff;
   logic [QptrBits-1:0]   wr_ptr_in;
   logic [QptrBits-1:0]   rd_ptr_in;
   logic [QcountBits-1:0] count_in;

   assign full  = (count_ff == QcountBits'(QueueDepth));
   assign empty = (count_ff == '0);
   assign rdata = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + QptrBits'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + QptrBits'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QcountBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QcountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QcountBits'(QueueDepth))
      else $error("queue count out of range");

endmodule

`default_nettype wire

// File: src/wjed_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 17 quotient bits.
`timescale 1ns / 1ps
`default_nettype none

module wjed_div
   import wjed_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [FieldBits:0]   rem_init,   // must be below twice the divisor
   input  wire logic [FracBits-1:0]  low_bits,   // dividend bits shifted in after
   input  wire logic [FieldBits-1:0] divisor,
   output div_status_type            status,
   output logic [FieldBits-1:0]      quotient
);

   logic                   busy_ff;
   logic                   done_ff;
   logic [DivStepBits-1:0] step_ff;
   logic [FieldBits:0]     rem_ff;
   logic [FracBits-1:0]    low_ff;
   logic [FieldBits-1:0]   dvs_ff;
   logic [FieldBits-1:0]   quo_ff;
   logic                   ge;
   logic [FieldBits:0]     diff;
   logic [FieldBits-1:0]   kept;

   always_comb begin
      ge   = (rem_ff >= {1'b0, dvs_ff});
      diff = rem_ff - {1'b0, dvs_ff};
      kept = ge ? diff[FieldBits-1:0] : rem_ff[FieldBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == DivStepBits'(DivSteps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               done_ff <= 1'b0;
               step_ff <= step_ff + DivStepBits'(1);
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
      if (start) begin
         rem_ff <= rem_init;
         low_ff <= low_bits;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[FieldBits-2:0], ge};
         rem_ff <= {kept, low_ff[FracBits-1]};
         low_ff <= {low_ff[FracBits-2:0], 1'b0};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

// File: src/wjed_back.sv
// Back end: counts, accumulates ratios, forms the final result and holds it.
`timescale 1ns / 1ps
`default_nettype none

module wjed_back
   import wjed_pkg::*;
#(
   parameter int WW = WeightBitsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   input  wire edge_flags_type       flags,
   input  wire logic [WW-1:0]        weight_hi,
   input  wire logic [WW-1:0]        weight_lo,
   output logic                      div_start,
   output logic [FieldBits:0]        div_rem_init,
   output logic [FracBits-1:0]       div_low_bits,
   output logic [FieldBits-1:0]      div_divisor,
   input  wire div_status_type       div_status,
   input  wire logic [FieldBits-1:0] div_quotient,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [FieldBits-1:0]      rsp_similarity,
   output logic [FieldBits-1:0]      rsp_distance,
   output logic [FieldBits-1:0]      rsp_union_count,
   output logic [FieldBits-1:0]      rsp_shared_count,
   output logic                      rsp_empty_union
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RATIO,
      S_FINAL,
      S_TOTAL,
      S_EMIT
   } state_type;

   state_type              state_ff;
   logic [FieldBits-1:0]   union_ff;
   logic [FieldBits-1:0]   shared_ff;
   logic [SumBits-1:0]     sum_ff;
   logic                   last_ff;
   logic [FieldBits-1:0]   sim_ff;
   logic                   empty_ff;
   logic                   start_ff;
   logic [FieldBits:0]     rem_ff;
   logic [FracBits-1:0]    low_ff;
   logic [FieldBits-1:0]   dvs_ff;
   logic                   rsp_valid_ff;
   logic [FieldBits-1:0]   rsp_sim_ff;
   logic [FieldBits-1:0]   rsp_dist_ff;
   logic [FieldBits-1:0]   rsp_union_ff;
   logic [FieldBits-1:0]   rsp_shared_ff;
   logic                   rsp_empty_ff;
   logic [SumBits:0]       sum_wide;
   logic                   too_big;

   assign q_pop    = (state_ff == S_IDLE) && !q_empty;
   assign sum_wide = {1'b0, sum_ff} + (SumBits + 1)'(div_quotient);
   // quotient needs more than 17 bits: clamp without dividing
   assign too_big  = ({1'b0, sum_ff[SumBits-1:FracBits+1]} >= union_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         union_ff     <= '0;
         shared_ff    <= '0;
         sum_ff       <= '0;
         last_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               start_ff <= !q_empty && flags.divide;
               if (!q_empty) begin
                  if (flags.is_union && (union_ff < CountCap)) begin
                     union_ff <= union_ff + FieldBits'(1);
                  end
                  if (flags.is_shared && (shared_ff < CountCap)) begin
                     shared_ff <= shared_ff + FieldBits'(1);
                  end
                  last_ff <= flags.last;
                  if (flags.divide) begin
                     rem_ff   <= (FieldBits + 1)'(weight_lo);
                     low_ff   <= '0;
                     dvs_ff   <= FieldBits'(weight_hi);
                     state_ff <= S_RATIO;
                  end else if (flags.last) begin
                     state_ff <= S_FINAL;
                  end
               end
            end
            S_RATIO: begin
               start_ff <= 1'b0;
               if (div_status.done) begin
                  sum_ff   <= sum_wide[SumBits] ? '1 : sum_wide[SumBits-1:0];
                  state_ff <= last_ff ? S_FINAL : S_IDLE;
               end
            end
            S_FINAL: begin
               start_ff <= (union_ff != '0) && !too_big;
               if (union_ff == '0) begin
                  sim_ff   <= '0;
                  empty_ff <= 1'b1;
                  state_ff <= S_EMIT;
               end else if (too_big) begin
                  sim_ff   <= OneQ16;
                  empty_ff <= 1'b0;
                  state_ff <= S_EMIT;
               end else begin
                  rem_ff   <= {1'b0, sum_ff[SumBits-1:FracBits]};
                  low_ff   <= sum_ff[FracBits-1:0];
                  dvs_ff   <= union_ff;
                  empty_ff <= 1'b0;
                  state_ff <= S_TOTAL;
               end
            end
            S_TOTAL: begin
               start_ff <= 1'b0;
               if (div_status.done) begin
                  sim_ff   <= (div_quotient > OneQ16) ? OneQ16 : div_quotient;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               start_ff <= 1'b0;
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_sim_ff    <= sim_ff;
                  rsp_dist_ff   <= empty_ff ? '0 : (OneQ16 - sim_ff);
                  rsp_union_ff  <= union_ff;
                  rsp_shared_ff <= shared_ff;
                  rsp_empty_ff  <= empty_ff;
                  union_ff      <= '0;
                  shared_ff     <= '0;
                  sum_ff        <= '0;
                  last_ff       <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               start_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign div_start        = start_ff;
   assign div_rem_init     = rem_ff;
   assign div_low_bits     = low_ff;
   assign div_divisor      = dvs_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_similarity   = rsp_sim_ff;
   assign rsp_distance     = rsp_dist_ff;
   assign rsp_union_count  = rsp_union_ff;
   assign rsp_shared_count = rsp_shared_ff;
   assign rsp_empty_union  = rsp_empty_ff;

   a_shared_le_union: assert property (@(posedge clock) disable iff (reset)
      shared_ff <= union_ff)
      else $error("shared count above union count");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> !div_status.busy)
      else $error("divider started while busy");

   a_sim_dist_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_empty_ff) |->
         ({1'b0, rsp_sim_ff} + {1'b0, rsp_dist_ff}) == {1'b0, OneQ16})
      else $error("similarity and distance do not add to one");

   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |->
         (rsp_sim_ff == '0) && (rsp_dist_ff == '0) && (rsp_union_ff == '0))
      else $error("empty result with nonzero fields");

endmodule

`default_nettype wire

// File: src/weighted_jaccard_edge_distance.sv
// Top level of the weighted Jaccard edge distance block.
// Usage:
//  - req channel: one transfer per edge slot, carrying presence flags and weights for both
//    graphs; req_last_edge closes a comparison. A transfer happens when req_valid is high
//    and req_stall is low.
//  - rsp channel: one transfer per comparison, on the slot marked last, giving similarity
//    and distance (Q1.16), the union and shared counts and the empty flag.
//  - Sequence: a slot that needs no ratio (not shared, or both weights zero) is counted by
//    the back end and needs no divider; a shared slot with a nonzero weight is taken, loads the
//    divider, runs 17 radix-2 steps and adds the quotient. Closing a comparison runs check, load,
//    17 steps, collect and output register, or only check and output register when the union
//    is empty or the ratio clamps. Entry to back end passes through the front register and queue.
//  - The front register and the four-entry queue keep taking slots while the back end is
//    dividing; req_stall rises only when the queue is full.
//  - A finished result sits in the output register; while rsp_stall is high the back end
//    holds it and waits, the queue still fills behind it.
//  - Reset (synchronous, active high) clears counts, ratio sum, queue and both valids.
//  - Only the low WEIGHT_BITS bits of each weight are used; the weights are unsigned.
`timescale 1ns / 1ps
`default_nettype none

module weighted_jaccard_edge_distance
   import wjed_pkg::*;
#(
   parameter int WEIGHT_BITS = WeightBitsDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_in_first,
   input  wire logic                      req_in_second,
   input  wire logic [WeightPortBits-1:0] req_weight_first,
   input  wire logic [WeightPortBits-1:0] req_weight_second,
   input  wire logic                      req_last_edge,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [FieldBits-1:0]           rsp_similarity,
   output logic [FieldBits-1:0]           rsp_distance,
   output logic [FieldBits-1:0]           rsp_union_count,
   output logic [FieldBits-1:0]           rsp_shared_count,
   output logic                           rsp_empty_union
);

   // weights wider than the port carry nothing extra
   localparam int WW      = (WEIGHT_BITS < WeightPortBits) ? WEIGHT_BITS : WeightPortBits;
   localparam int QDATA_W = EdgeFlagBits + 2 * WW;

   logic                 q_push;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_empty;
   logic [QDATA_W-1:0]   q_wdata;
   logic [QDATA_W-1:0]   q_rdata;
   edge_flags_type       front_flags;
   logic [WW-1:0]        front_hi;
   logic [WW-1:0]        front_lo;
   edge_flags_type       back_flags;
   logic [WW-1:0]        back_hi;
   logic [WW-1:0]        back_lo;
   logic                 div_start;
   logic [FieldBits:0]   div_rem_init;
   logic [FracBits-1:0]  div_low_bits;
   logic [FieldBits-1:0] div_divisor;
   div_status_type       div_status;
   logic [FieldBits-1:0] div_quotient;

   wjed_front #(
      .WW (WW)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_first      (req_in_first),
      .req_in_second     (req_in_second),
      .req_weight_first  (req_weight_first),
      .req_weight_second (req_weight_second),
      .req_last_edge     (req_last_edge),
      .q_full            (q_full),
      .q_push            (q_push),
      .flags             (front_flags),
      .weight_hi         (front_hi),
      .weight_lo         (front_lo)
   );

   // queue entry: flags, larger weight, smaller weight
   assign q_wdata = {front_flags, front_hi, front_lo};
   assign {back_flags, back_hi, back_lo} = q_rdata;

   wjed_queue #(
      .DATA_W (QDATA_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   // one divider serves both the per-edge ratio and the final sum / union
   wjed_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem_init),
      .low_bits (div_low_bits),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   wjed_back #(
      .WW (WW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .flags            (back_flags),
      .weight_hi        (back_hi),
      .weight_lo        (back_lo),
      .div_start        (div_start),
      .div_rem_init     (div_rem_init),
      .div_low_bits     (div_low_bits),
      .div_divisor      (div_divisor),
      .div_status       (div_status),
      .div_quotient     (div_quotient),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_similarity   (rsp_similarity),
      .rsp_distance     (rsp_distance),
      .rsp_union_count  (rsp_union_count),
      .rsp_shared_count (rsp_shared_count),
      .rsp_empty_union  (rsp_empty_union)
   );

endmodule

`default_nettype wire
